### design/minv_pkg.sv
package minv_pkg;

	localparam int NLANE = 9;

	// Cofactor k = m[a]*m[b] - m[c]*m[d], matrix elements row-major
	localparam int COF_IDX [NLANE][4] = '{
		'{4, 8, 5, 7},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{2, 3, 0, 5},
		'{3, 7, 4, 6},
		'{1, 6, 0, 7},
		'{0, 4, 1, 3}
	};

	// Cofactors paired with m00, m01, m02 in the determinant expansion
	localparam int DET_COF [3] = '{0, 3, 6};

	typedef struct packed {
		logic             valid;
		logic             singular;
		logic             det_neg;
		logic [NLANE-1:0] neg;
	} ctl_t;

endpackage

### design/minv_mat_if.sv
interface minv_mat_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

### design/minv_inv_if.sv
interface minv_inv_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [W-1:0] determinant;
	logic singular;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		determinant, singular, input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		determinant, singular, output ready);
endinterface

### design/minv_div_stage.sv
module minv_div_stage #(
	parameter int W   = 32,
	parameter int RW  = 134,
	parameter int DDW = 100,
	parameter int B   = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  minv_pkg::ctl_t                         ctl_in,
	input  logic [DDW-1:0]                         d_in,
	input  logic [minv_pkg::NLANE-1:0][RW-1:0]     rem_in,
	input  logic [minv_pkg::NLANE-1:0][W+1:0]      q_in,
	output minv_pkg::ctl_t                         ctl_out,
	output logic [DDW-1:0]                         d_out,
	output logic [minv_pkg::NLANE-1:0][RW-1:0]     rem_out,
	output logic [minv_pkg::NLANE-1:0][W+1:0]      q_out
);

	logic [RW-1:0] t;
	logic [minv_pkg::NLANE-1:0][RW:0]   diff;
	logic [minv_pkg::NLANE-1:0][RW-1:0] rem_nx;
	logic [minv_pkg::NLANE-1:0][W+1:0]  q_nx;

	// one restoring step: quotient bit B of every lane
	always_comb begin
		t = {{(RW-DDW){1'b0}}, d_in} << B;
		for (int k = 0; k < minv_pkg::NLANE; k++) begin
			diff[k]   = {1'b0, rem_in[k]} - {1'b0, t};
			rem_nx[k] = diff[k][RW] ? rem_in[k] : diff[k][RW-1:0];
			q_nx[k]   = q_in[k];
			q_nx[k][B] = ~diff[k][RW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out   <= d_in;
			rem_out <= rem_nx;
			q_out   <= q_nx;
		end
	end

endmodule

### design/matrix_inverse_3x3_unit.sv
// Throughput: one matrix per cycle; the whole pipeline advances together and
// holds while a finished result waits at the output register.
// Depth is set by the divider: one restoring quotient bit per stage, nine lanes.
// Reset clears the valid and control bits; data registers are not reset.
module matrix_inverse_3x3_unit #(
	parameter int ELEMENT_WIDTH = 32,
	parameter int FRAC_BITS     = 16
) (
	input logic        clk,
	input logic        arst_n,
	minv_mat_if.sink   mat,
	minv_inv_if.source inv
);

	localparam int W   = ELEMENT_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int CW  = 2 * W + 1;
	localparam int XW  = 3 * W + 1;
	localparam int DW  = 3 * W + 3;
	localparam int DDW = DW + 1;
	localparam int NW  = CW + 2 * F + 2;
	localparam int RW  = (NW > DDW + W + 1) ? NW : DDW + W + 1;
	localparam int QW  = W + 2;
	localparam int NL  = minv_pkg::NLANE;

	localparam logic [W:0]    LIM  = {2'b01, {(W-1){1'b0}}};
	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [DW:0]   HALF = {{(DW-2*F+1){1'b0}}, 1'b1, {(2*F-1){1'b0}}};
	localparam logic [DW:0]   LIMX = {{(DW-W){1'b0}}, LIM};

	logic en;
	logic ov_q;

	assign en        = !ov_q || inv.ready;
	assign mat.ready = en;

	logic signed [W-1:0] m_in [9];
	assign m_in[0] = mat.m00;
	assign m_in[1] = mat.m01;
	assign m_in[2] = mat.m02;
	assign m_in[3] = mat.m10;
	assign m_in[4] = mat.m11;
	assign m_in[5] = mat.m12;
	assign m_in[6] = mat.m20;
	assign m_in[7] = mat.m21;
	assign m_in[8] = mat.m22;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// products for the cofactors
	logic signed [PW-1:0] pa_s1 [NL];
	logic signed [PW-1:0] pb_s1 [NL];
	logic signed [W-1:0]  row_s1 [3];
	logic signed [CW-1:0] cof_s2 [NL];
	logic signed [W-1:0]  row_s2 [3];
	logic signed [PW:0]   pl_s3 [3];
	logic signed [PW:0]   ph_s3 [3];
	logic signed [CW-1:0] cof_s3 [NL];
	logic signed [XW-1:0] prod_s4 [3];
	logic signed [CW-1:0] cof_s4 [NL];
	logic signed [DW-1:0] det_s5;
	logic signed [CW-1:0] cof_s5 [NL];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				pa_s1[k] <= m_in[minv_pkg::COF_IDX[k][0]] * m_in[minv_pkg::COF_IDX[k][1]];
				pb_s1[k] <= m_in[minv_pkg::COF_IDX[k][2]] * m_in[minv_pkg::COF_IDX[k][3]];
				cof_s2[k] <= $signed({pa_s1[k][PW-1], pa_s1[k]})
					- $signed({pb_s1[k][PW-1], pb_s1[k]});
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
			end
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= m_in[j];
				row_s2[j] <= row_s1[j];
				// row element times cofactor, split into low and high halves
				pl_s3[j] <= row_s2[j]
					* $signed({1'b0, cof_s2[minv_pkg::DET_COF[j]][W-1:0]});
				ph_s3[j] <= row_s2[j] * $signed(cof_s2[minv_pkg::DET_COF[j]][CW-1:W]);
				prod_s4[j] <= $signed({ph_s3[j], {W{1'b0}}})
					+ $signed({{W{pl_s3[j][PW]}}, pl_s3[j]});
			end
			det_s5 <= $signed({{2{prod_s4[0][XW-1]}}, prod_s4[0]})
				+ $signed({{2{prod_s4[1][XW-1]}}, prod_s4[1]})
				+ $signed({{2{prod_s4[2][XW-1]}}, prod_s4[2]});
		end
	end

	// divider operands: N = 2|cof|*2^(2F) + |det|, D = 2|det|
	minv_pkg::ctl_t               ctl_d [QW+1];
	logic [DDW-1:0]               d_d   [QW+1];
	logic [NL-1:0][RW-1:0]        rem_d [QW+1];
	logic [NL-1:0][QW-1:0]        q_d   [QW+1];

	logic                         det_neg;
	logic [DW-1:0]                det_mag;
	logic [NL-1:0][CW-1:0]        cof_mag;
	logic [NL-1:0][RW-1:0]        num;
	minv_pkg::ctl_t               ctl_nx;

	always_comb begin
		det_neg = det_s5[DW-1];
		det_mag = det_neg ? (~det_s5 + 1'b1) : det_s5;
		ctl_nx.valid    = v_s5;
		ctl_nx.singular = (det_s5 == '0);
		ctl_nx.det_neg  = det_neg;
		for (int k = 0; k < NL; k++) begin
			cof_mag[k] = cof_s5[k][CW-1] ? (~cof_s5[k] + 1'b1) : cof_s5[k];
			num[k] = {{(RW-NW+1){1'b0}}, cof_mag[k], {(2*F+1){1'b0}}}
				+ {{(RW-DW){1'b0}}, det_mag};
			ctl_nx.neg[k] = cof_s5[k][CW-1] ^ det_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d[0] <= '0;
		end else if (en) begin
			ctl_d[0] <= ctl_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_d[0]   <= {det_mag, 1'b0};
			rem_d[0] <= num;
			q_d[0]   <= '0;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		minv_div_stage #(
			.W  (W),
			.RW (RW),
			.DDW(DDW),
			.B  (QW - 1 - i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_d[i]),
			.d_in   (d_d[i]),
			.rem_in (rem_d[i]),
			.q_in   (q_d[i]),
			.ctl_out(ctl_d[i+1]),
			.d_out  (d_d[i+1]),
			.rem_out(rem_d[i+1]),
			.q_out  (q_d[i+1])
		);
	end

	// saturation, sign and singular masking
	minv_pkg::ctl_t  ctl_f;
	logic [W-1:0]    r_nx [NL];
	logic [W-1:0]    det_nx;
	logic [W:0]      mq;
	logic            over;
	logic [DW:0]     dsum;
	logic [DW:0]     dq;

	always_comb begin
		ctl_f = ctl_d[QW];
		for (int k = 0; k < NL; k++) begin
			over = q_d[QW][k][QW-1];
			mq   = q_d[QW][k][W:0];
			if (!ctl_f.neg[k]) begin
				r_nx[k] = (over || mq > LIM - 1'b1) ? MAXV : mq[W-1:0];
			end else begin
				r_nx[k] = (over || mq > LIM) ? MINV : (~mq[W-1:0] + 1'b1);
			end
			if (ctl_f.singular) begin
				r_nx[k] = '0;
			end
		end
		dsum = {1'b0, d_d[QW][DDW-1:1]} + HALF;
		dq   = dsum >> (2 * F);
		if (!ctl_f.det_neg) begin
			det_nx = (dq > LIMX - 1'b1) ? MAXV : dq[W-1:0];
		end else begin
			det_nx = (dq > LIMX) ? MINV : (~dq[W-1:0] + 1'b1);
		end
		if (ctl_f.singular) begin
			det_nx = '0;
		end
	end

	logic [W-1:0] r_q [NL];
	logic [W-1:0] det_q;
	logic         sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= ctl_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q    <= r_nx;
			det_q  <= det_nx;
			sing_q <= ctl_f.singular;
		end
	end

	assign inv.valid       = ov_q;
	assign inv.r00         = r_q[0];
	assign inv.r01         = r_q[1];
	assign inv.r02         = r_q[2];
	assign inv.r10         = r_q[3];
	assign inv.r11         = r_q[4];
	assign inv.r12         = r_q[5];
	assign inv.r20         = r_q[6];
	assign inv.r21         = r_q[7];
	assign inv.r22         = r_q[8];
	assign inv.determinant = det_q;
	assign inv.singular    = sing_q;

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.singular |-> inv.determinant == '0 && inv.r00 == '0
			&& inv.r11 == '0 && inv.r22 == '0)
		else $error("singular result carries nonzero data");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!inv.valid |-> mat.ready)
		else $error("input blocked with empty output register");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && !inv.ready |-> !mat.ready)
		else $error("input taken while output transfer stalled");

endmodule

### test/tb_top.sv
module tb_top;

	localparam int EW = 32;
	localparam int FB = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = EW + 20;

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [191:0] wide_t;

	typedef struct {
		elem_t e[9];
	} matrix_t;

	typedef struct {
		elem_t r[9];
		elem_t det;
		logic  sing;
	} inverse_t;

	typedef enum int {
		MK_WELL,
		MK_SMALL,
		MK_FULL,
		MK_SINGULAR,
		MK_MODERATE
	} mat_kind_t;

	// cofactor k = e[a]*e[b] - e[c]*e[d]
	localparam int ADJ_TERM [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	logic clk;
	logic arst_n;

	minv_mat_if #(.W(EW)) mat_if ();
	minv_inv_if #(.W(EW)) inv_if ();

	matrix_inverse_3x3_unit #(
		.ELEMENT_WIDTH(EW),
		.FRAC_BITS    (FB)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.mat   (mat_if),
		.inv   (inv_if)
	);

	inverse_t pending_inv[$];
	int       error_count;
	int       cycle_count;
	int       idle_pct;
	int       stall_pct;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// round to nearest, ties away from zero, then saturate
	function automatic elem_t div_round_sat(wide_t n, wide_t d);
		logic  neg;
		wide_t an;
		wide_t ad;
		wide_t q;
		neg = n[191] ^ d[191];
		an  = n[191] ? -n : n;
		ad  = d[191] ? -d : d;
		q   = (2 * an + ad) / (2 * ad);
		if (!neg) begin
			if (q > wide_t'(2147483647))
				return elem_t'(32'h7FFF_FFFF);
			return elem_t'(q);
		end
		if (q > wide_t'(64'd2147483648))
			return elem_t'(32'h8000_0000);
		return elem_t'(-q);
	endfunction

	function automatic inverse_t inverse_of(matrix_t a);
		wide_t    x[9];
		wide_t    cof[9];
		wide_t    det;
		wide_t    scale;
		inverse_t res;
		for (int k = 0; k < 9; k++)
			x[k] = a.e[k];
		for (int k = 0; k < 9; k++)
			cof[k] = x[ADJ_TERM[k][0]] * x[ADJ_TERM[k][1]]
				- x[ADJ_TERM[k][2]] * x[ADJ_TERM[k][3]];
		det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
		scale = wide_t'(1) <<< (2 * FB);
		if (det == 0) begin
			for (int k = 0; k < 9; k++)
				res.r[k] = '0;
			res.det  = '0;
			res.sing = 1'b1;
			return res;
		end
		for (int k = 0; k < 9; k++)
			res.r[k] = div_round_sat(cof[k] * scale, det);
		res.det  = div_round_sat(det, scale);
		res.sing = 1'b0;
		return res;
	endfunction

	function automatic elem_t rand_elem(int lo, int hi);
		return elem_t'($urandom_range(hi - lo, 0) + lo);
	endfunction

	function automatic matrix_t rand_matrix(mat_kind_t kind);
		matrix_t a;
		int      sel;
		for (int k = 0; k < 9; k++) begin
			case (kind)
				MK_WELL: begin
					if (k % 4 == 0)
						a.e[k] = ($urandom_range(1) ? 1 : -1) * rand_elem(1 << 15, 5 << 16);
					else
						a.e[k] = rand_elem(-65535, 65535);
				end
				MK_SMALL: a.e[k] = rand_elem(-256, 255);
				MK_MODERATE: a.e[k] = rand_elem(-(1 << 22), 1 << 22);
				default: a.e[k] = elem_t'($urandom);
			endcase
		end
		if (kind == MK_SINGULAR) begin
			sel = $urandom_range(3);
			for (int c = 0; c < 3; c++) begin
				case (sel)
					0: a.e[6 + c] = a.e[c];
					1: a.e[3 + c] = -a.e[c];
					2: a.e[3 * c + 2] = a.e[3 * c];
					default: a.e[3 * c + 1] = '0;
				endcase
			end
		end
		return a;
	endfunction

	function automatic matrix_t mat_of(int d0, int d1, int d2, int off);
		matrix_t a;
		for (int k = 0; k < 9; k++)
			a.e[k] = elem_t'(off);
		a.e[0] = elem_t'(d0);
		a.e[4] = elem_t'(d1);
		a.e[8] = elem_t'(d2);
		return a;
	endfunction

	task automatic put_matrix(matrix_t a);
		mat_if.m00 <= a.e[0];
		mat_if.m01 <= a.e[1];
		mat_if.m02 <= a.e[2];
		mat_if.m10 <= a.e[3];
		mat_if.m11 <= a.e[4];
		mat_if.m12 <= a.e[5];
		mat_if.m20 <= a.e[6];
		mat_if.m21 <= a.e[7];
		mat_if.m22 <= a.e[8];
	endtask

	task automatic send_matrix(matrix_t a);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			mat_if.valid <= 1'b0;
			@(posedge clk);
		end
		mat_if.valid <= 1'b1;
		put_matrix(a);
		do begin
			@(negedge clk);
			taken = mat_if.ready;
			@(posedge clk);
		end while (!taken);
		pending_inv.push_back(inverse_of(a));
	endtask

	task automatic stop_sending();
		mat_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk)
		inv_if.ready <= ($urandom_range(99) >= stall_pct);

	always @(negedge clk) begin
		inverse_t want;
		elem_t    got[9];
		if (arst_n && inv_if.valid && inv_if.ready) begin
			got = '{inv_if.r00, inv_if.r01, inv_if.r02, inv_if.r10, inv_if.r11,
				inv_if.r12, inv_if.r20, inv_if.r21, inv_if.r22};
			if (pending_inv.size() == 0) begin
				$display("%0t: unexpected result transfer", $time);
				error_count++;
			end else begin
				want = pending_inv.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== want.r[k]) begin
						$display("%0t: r%0d%0d expected %h actual %h", $time,
							k / 3, k % 3, want.r[k], got[k]);
						error_count++;
					end
				if (inv_if.determinant !== want.det) begin
					$display("%0t: determinant expected %h actual %h", $time,
						want.det, inv_if.determinant);
					error_count++;
				end
				if (inv_if.singular !== want.sing) begin
					$display("%0t: singular expected %b actual %b", $time,
						want.sing, inv_if.singular);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic test_special_cases();
		matrix_t a;
		send_matrix(mat_of(1 << FB, 1 << FB, 1 << FB, 0));
		send_matrix(mat_of(0, 0, 0, 0));
		send_matrix(mat_of(2 << FB, -(4 << FB), 1 << (FB - 1), 0));
		send_matrix(mat_of(1, 1, 1, 0));
		send_matrix(mat_of(-1, 1, 1, 0));
		send_matrix(mat_of(1 << FB, 1 << FB, 1, 0));
		send_matrix(mat_of(3 << FB, 3 << FB, 3 << FB, 0));
		send_matrix(mat_of(1 << FB, 1 << FB, 1 << FB, 1 << FB));
		send_matrix(mat_of(2 << FB, 2 << FB, 2 << FB, 1 << FB));
		send_matrix(mat_of(3 << FB, 1 << FB, 1 << FB, 0));
		send_matrix(mat_of(1 << 20, 1 << 20, 1 << 20, 0));
		send_matrix(mat_of(1 << 24, 1 << 24, 1 << 24, 0));
		a = mat_of(1 << FB, 1 << FB, 1 << FB, 0);
		a.e[1] = 5 << FB;
		a.e[5] = -(7 << FB);
		a.e[6] = 9 << FB;
		send_matrix(a);
		send_matrix(rand_matrix(MK_SINGULAR));
	endtask

	task automatic test_extremes();
		int mn;
		int mx;
		mn = 32'sh8000_0000;
		mx = 32'sh7FFF_FFFF;
		send_matrix(mat_of(mx, mx, mx, 0));
		send_matrix(mat_of(mn, mn, mn, 0));
		send_matrix(mat_of(mn, mx, mn, mx));
		send_matrix(mat_of(mx, mn, mx, mn));
		send_matrix(mat_of(mx, mx, mx, mx));
		send_matrix(mat_of(mn, mn, mn, mn));
		send_matrix(mat_of(-1, -1, -1, -1));
		send_matrix(mat_of(mx, 1, 1, 0));
		send_matrix(mat_of(mn, -1, 1, 0));
	endtask

	task automatic test_random_traffic(int idle, int stall, int count);
		int pick;
		idle_pct  = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35)      send_matrix(rand_matrix(MK_WELL));
			else if (pick < 50) send_matrix(rand_matrix(MK_SMALL));
			else if (pick < 65) send_matrix(rand_matrix(MK_MODERATE));
			else if (pick < 85) send_matrix(rand_matrix(MK_FULL));
			else                send_matrix(rand_matrix(MK_SINGULAR));
		end
		stop_sending();
	endtask

	initial begin
		error_count  = 0;
		cycle_count  = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		arst_n       = 1'b0;
		mat_if.valid = 1'b0;
		inv_if.ready = 1'b0;
		put_matrix(mat_of(0, 0, 0, 0));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_extremes();
		stop_sending();
		test_random_traffic(0, 0, 207);
		test_random_traffic(82, 0, 207);
		test_random_traffic(0, 82, 207);
		test_random_traffic(22, 22, 207);

		wait (pending_inv.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
